// File: rtl/owbm_pkg.sv
// Shared types, codes and reset values of the single-wire bus master.
`default_nettype none

package owbm_pkg;

  localparam int unsigned CFG_AW = 5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_W_LOW     = 4'd5,
    PH_W_REL     = 4'd6,
    PH_R_LOW     = 4'd7,
    PH_R_WAIT    = 4'd8,
    PH_R_TAIL    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_PRES_WAIT     = 3'd2,
    REG_PRES_LOW      = 3'd3,
    REG_SLOT_START    = 3'd4,
    REG_SAMPLE_DELAY  = 3'd5,
    REG_READ_TAIL     = 3'd6,
    REG_WRITE_SLOT    = 3'd7
  } reg_idx_t;

  localparam logic [9:0] RST_RESET_LOW     = 10'd750;
  localparam logic [7:0] RST_RESET_RELEASE = 8'd15;
  localparam logic [7:0] RST_PRES_WAIT     = 8'd200;
  localparam logic [7:0] RST_PRES_LOW      = 8'd240;
  localparam logic [3:0] RST_SLOT_START    = 4'd2;
  localparam logic [5:0] RST_SAMPLE_DELAY  = 6'd12;
  localparam logic [6:0] RST_READ_TAIL     = 7'd50;
  localparam logic [6:0] RST_WRITE_SLOT    = 7'd60;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] reset_release_time;
    logic [7:0] presence_wait_limit;
    logic [7:0] presence_low_limit;
    logic [3:0] slot_start_time;
    logic [5:0] read_sample_delay;
    logic [6:0] read_tail_time;
    logic [6:0] write_slot_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] write_value;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_value;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/owbm_in_if.sv
// Command/tick channel: valid, ready and one input item.
`default_nettype none

interface owbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] write_value;
  logic       line_level;

  modport source (output valid, output cmd, output write_value, output line_level,
                  input ready);
  modport sink (input valid, input cmd, input write_value, input line_level,
                output ready);
endinterface

`default_nettype wire

// File: rtl/owbm_out_if.sv
// Result channel: valid, ready and one result item.
`default_nettype none

interface owbm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       device_present;
  logic [7:0] read_value;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output device_present, output read_value, output rejected,
                  input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input device_present, input read_value, input rejected,
                output ready);
endinterface

`default_nettype wire

// File: rtl/owbm_cfg_regs.sv
// APB-style timing register file.
`default_nettype none

module owbm_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [owbm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready,
  output      owbm_pkg::cfg_t             cfg
);

  owbm_pkg::cfg_t     cfg_r;
  owbm_pkg::cfg_t     cfg_nxt;
  owbm_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = owbm_pkg::reg_idx_t'(paddr[owbm_pkg::CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        owbm_pkg::REG_RESET_LOW:     cfg_nxt.reset_low_time      = pwdata[9:0];
        owbm_pkg::REG_RESET_RELEASE: cfg_nxt.reset_release_time  = pwdata[7:0];
        owbm_pkg::REG_PRES_WAIT:     cfg_nxt.presence_wait_limit = pwdata[7:0];
        owbm_pkg::REG_PRES_LOW:      cfg_nxt.presence_low_limit  = pwdata[7:0];
        owbm_pkg::REG_SLOT_START:    cfg_nxt.slot_start_time     = pwdata[3:0];
        owbm_pkg::REG_SAMPLE_DELAY:  cfg_nxt.read_sample_delay   = pwdata[5:0];
        owbm_pkg::REG_READ_TAIL:     cfg_nxt.read_tail_time      = pwdata[6:0];
        owbm_pkg::REG_WRITE_SLOT:    cfg_nxt.write_slot_time     = pwdata[6:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      owbm_pkg::REG_RESET_LOW:     prdata = {22'd0, cfg_r.reset_low_time};
      owbm_pkg::REG_RESET_RELEASE: prdata = {24'd0, cfg_r.reset_release_time};
      owbm_pkg::REG_PRES_WAIT:     prdata = {24'd0, cfg_r.presence_wait_limit};
      owbm_pkg::REG_PRES_LOW:      prdata = {24'd0, cfg_r.presence_low_limit};
      owbm_pkg::REG_SLOT_START:    prdata = {28'd0, cfg_r.slot_start_time};
      owbm_pkg::REG_SAMPLE_DELAY:  prdata = {26'd0, cfg_r.read_sample_delay};
      owbm_pkg::REG_READ_TAIL:     prdata = {25'd0, cfg_r.read_tail_time};
      owbm_pkg::REG_WRITE_SLOT:    prdata = {25'd0, cfg_r.write_slot_time};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time      <= owbm_pkg::RST_RESET_LOW;
      cfg_r.reset_release_time  <= owbm_pkg::RST_RESET_RELEASE;
      cfg_r.presence_wait_limit <= owbm_pkg::RST_PRES_WAIT;
      cfg_r.presence_low_limit  <= owbm_pkg::RST_PRES_LOW;
      cfg_r.slot_start_time     <= owbm_pkg::RST_SLOT_START;
      cfg_r.read_sample_delay   <= owbm_pkg::RST_SAMPLE_DELAY;
      cfg_r.read_tail_time      <= owbm_pkg::RST_READ_TAIL;
      cfg_r.write_slot_time     <= owbm_pkg::RST_WRITE_SLOT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/owbm_core.sv
// Input register and per-microsecond bus sequencer.
`default_nettype none

module owbm_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  owbm_in_if.sink             in_ch,
  input  wire owbm_pkg::cfg_t cfg,
  input  wire logic           space,
  output      logic           push,
  output      owbm_pkg::res_t res
);

  logic            in_vld_r;
  owbm_pkg::item_t item_r;
  logic            accept;

  owbm_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [9:0]       tick_r, tick_nxt, tick_base, tick_inc;
  logic [2:0]       bit_idx_r, bit_idx_nxt, bit_base;
  logic [7:0]       shift_r, shift_nxt, shift_base, shift_smp;
  logic             present_r, present_nxt;
  logic [7:0]       rdbyte_r, rdbyte_nxt;

  logic             start;
  logic [9:0]       dur, dur_eff;
  logic             tmr_fin;
  logic             drive, done, rej;

  assign push        = in_vld_r && space;
  assign in_ch.ready = !in_vld_r || push;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (push) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{cmd: in_ch.cmd, write_value: in_ch.write_value,
                  line_level: in_ch.line_level};
    end
  end

  // A command taken while idle makes this same item its first microsecond
  assign start = (phase_r == owbm_pkg::PH_IDLE) &&
                 (item_r.cmd != owbm_pkg::CMD_TICK);

  always_comb begin
    cur_phase  = phase_r;
    tick_base  = tick_r;
    bit_base   = bit_idx_r;
    shift_base = shift_r;
    if (start) begin
      tick_base  = 10'd0;
      bit_base   = 3'd0;
      shift_base = 8'd0;
      case (owbm_pkg::cmd_t'(item_r.cmd))
        owbm_pkg::CMD_RESET: cur_phase = owbm_pkg::PH_RST_LOW;
        owbm_pkg::CMD_WRITE: begin
          cur_phase  = owbm_pkg::PH_W_LOW;
          shift_base = item_r.write_value;
        end
        owbm_pkg::CMD_READ:  cur_phase = owbm_pkg::PH_R_LOW;
        default:             cur_phase = owbm_pkg::PH_IDLE;
      endcase
    end
  end

  assign tick_inc = tick_base + 10'd1;

  // Length of the current timed part; zero counts as one microsecond
  always_comb begin
    case (cur_phase)
      owbm_pkg::PH_RST_LOW: dur = cfg.reset_low_time;
      owbm_pkg::PH_RST_REL: dur = {2'd0, cfg.reset_release_time};
      owbm_pkg::PH_W_LOW:   dur = shift_base[0] ? {6'd0, cfg.slot_start_time}
                                                : {3'd0, cfg.write_slot_time};
      owbm_pkg::PH_W_REL:   dur = shift_base[0] ? {3'd0, cfg.write_slot_time}
                                                : {6'd0, cfg.slot_start_time};
      owbm_pkg::PH_R_LOW:   dur = {6'd0, cfg.slot_start_time};
      owbm_pkg::PH_R_WAIT:  dur = {4'd0, cfg.read_sample_delay};
      owbm_pkg::PH_R_TAIL:  dur = {3'd0, cfg.read_tail_time};
      default:              dur = 10'd1;
    endcase
  end

  assign dur_eff   = (dur == 10'd0) ? 10'd1 : dur;
  assign tmr_fin   = tick_inc >= dur_eff;
  assign shift_smp = (tick_base == 10'd0) ? {item_r.line_level, shift_base[7:1]} : shift_base;

  // Next state
  always_comb begin
    phase_nxt   = cur_phase;
    tick_nxt    = tick_base;
    bit_idx_nxt = bit_base;
    shift_nxt   = shift_base;
    present_nxt = present_r;
    rdbyte_nxt  = rdbyte_r;
    case (cur_phase)
      owbm_pkg::PH_IDLE: begin
      end
      owbm_pkg::PH_RST_LOW: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) begin
          phase_nxt = (cfg.reset_release_time != 8'd0) ? owbm_pkg::PH_RST_REL
                                                       : owbm_pkg::PH_PRES_WAIT;
        end
      end
      owbm_pkg::PH_RST_REL: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) phase_nxt = owbm_pkg::PH_PRES_WAIT;
      end
      owbm_pkg::PH_PRES_WAIT: begin
        if (item_r.line_level) begin
          tick_nxt = tick_inc;
          if (tick_inc >= {2'd0, cfg.presence_wait_limit}) begin
            present_nxt = 1'b0;
            phase_nxt   = owbm_pkg::PH_IDLE;
            tick_nxt    = 10'd0;
          end
        end else if (cfg.presence_low_limit <= 8'd1) begin
          present_nxt = 1'b0;
          phase_nxt   = owbm_pkg::PH_IDLE;
          tick_nxt    = 10'd0;
        end else begin
          tick_nxt  = 10'd1;
          phase_nxt = owbm_pkg::PH_PRES_LOW;
        end
      end
      owbm_pkg::PH_PRES_LOW: begin
        if (item_r.line_level) begin
          present_nxt = 1'b1;
          phase_nxt   = owbm_pkg::PH_IDLE;
          tick_nxt    = 10'd0;
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= {2'd0, cfg.presence_low_limit}) begin
            present_nxt = 1'b0;
            phase_nxt   = owbm_pkg::PH_IDLE;
            tick_nxt    = 10'd0;
          end
        end
      end
      owbm_pkg::PH_W_LOW: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) phase_nxt = owbm_pkg::PH_W_REL;
      end
      owbm_pkg::PH_W_REL: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) begin
          shift_nxt = {1'b0, shift_base[7:1]};
          if (bit_base == 3'd7) begin
            bit_idx_nxt = 3'd0;
            phase_nxt   = owbm_pkg::PH_IDLE;
          end else begin
            bit_idx_nxt = bit_base + 3'd1;
            phase_nxt   = owbm_pkg::PH_W_LOW;
          end
        end
      end
      owbm_pkg::PH_R_LOW: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) phase_nxt = owbm_pkg::PH_R_WAIT;
      end
      owbm_pkg::PH_R_WAIT: begin
        tick_nxt = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) phase_nxt = owbm_pkg::PH_R_TAIL;
      end
      owbm_pkg::PH_R_TAIL: begin
        // line sampled on the first microsecond of the tail
        shift_nxt = shift_smp;
        tick_nxt  = tmr_fin ? 10'd0 : tick_inc;
        if (tmr_fin) begin
          if (bit_base == 3'd7) begin
            bit_idx_nxt = 3'd0;
            rdbyte_nxt  = shift_smp;
            phase_nxt   = owbm_pkg::PH_IDLE;
          end else begin
            bit_idx_nxt = bit_base + 3'd1;
            phase_nxt   = owbm_pkg::PH_R_LOW;
          end
        end
      end
      default: begin
        phase_nxt = owbm_pkg::PH_IDLE;
        tick_nxt  = 10'd0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    drive = 1'b0;
    done  = 1'b0;
    case (cur_phase)
      owbm_pkg::PH_RST_LOW, owbm_pkg::PH_W_LOW, owbm_pkg::PH_R_LOW: begin
        drive = 1'b1;
        done  = (phase_nxt == owbm_pkg::PH_IDLE);
      end
      owbm_pkg::PH_RST_REL, owbm_pkg::PH_PRES_WAIT, owbm_pkg::PH_PRES_LOW,
      owbm_pkg::PH_W_REL, owbm_pkg::PH_R_WAIT, owbm_pkg::PH_R_TAIL: begin
        done = (phase_nxt == owbm_pkg::PH_IDLE);
      end
      default: begin
        drive = 1'b0;
        done  = 1'b0;
      end
    endcase
    rej = (phase_r != owbm_pkg::PH_IDLE) && (item_r.cmd != owbm_pkg::CMD_TICK);
  end

  assign res = '{drive_low: drive,
                 busy_res: (phase_nxt != owbm_pkg::PH_IDLE),
                 done_res: done,
                 device_present: present_nxt,
                 read_value: rdbyte_nxt,
                 rejected: rej};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= owbm_pkg::PH_IDLE;
      tick_r    <= 10'd0;
      bit_idx_r <= 3'd0;
      shift_r   <= 8'd0;
      present_r <= 1'b0;
      rdbyte_r  <= 8'd0;
    end else if (push) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      present_r <= present_nxt;
      rdbyte_r  <= rdbyte_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.done_res |-> !res.busy_res)
    else $error("operation reported done while still busy");

  a_drive_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.drive_low |-> res.busy_res || res.done_res)
    else $error("line driven outside an operation");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == owbm_pkg::PH_IDLE && !(push && start) |=> phase_r == owbm_pkg::PH_IDLE)
    else $error("left idle without a command");

  a_bit_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == owbm_pkg::PH_IDLE |-> bit_idx_r == 3'd0)
    else $error("bit index not cleared at idle");
`endif

endmodule

`default_nettype wire

// File: rtl/owbm_out_buf.sv
// Two-entry result buffer that decouples the result channel from the sequencer.
`default_nettype none

module owbm_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire owbm_pkg::res_t din,
  output      logic           space,
  owbm_out_if.source          out_ch
);

  owbm_pkg::res_t ent0_r, ent1_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.drive_low      = ent0_r.drive_low;
  assign out_ch.busy_res       = ent0_r.busy_res;
  assign out_ch.done_res       = ent0_r.done_res;
  assign out_ch.device_present = ent0_r.device_present;
  assign out_ch.read_value     = ent0_r.read_value;
  assign out_ch.rejected       = ent0_r.rejected;

  assign pop   = out_ch.valid && out_ch.ready;
  assign space = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head always sits in entry 0
  always_ff @(posedge clk) begin
    if (pop) begin
      ent0_r <= (push && cnt_r == 2'd1) ? din : ent1_r;
    end else if (push && cnt_r == 2'd0) begin
      ent0_r <= din;
    end
    if (push && ((pop && cnt_r == 2'd2) || (!pop && cnt_r == 2'd1))) begin
      ent1_r <= din;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("transfer pushed into full result buffer");
`endif

endmodule

`default_nettype wire

// File: rtl/one_wire_bus_master.sv
// Single-wire bus master: top level.
//
//  channel   | ports                               | role
//  ----------+-------------------------------------+---------------------------------
//  in_ch     | valid/ready, cmd, write_value, line | one transfer per microsecond tick
//  out_ch    | valid/ready, drive_low .. rejected  | one result transfer per tick
//  cfg       | psel/penable/pwrite/paddr/pwdata    | timing registers at 4*index
//
// One tick per clock cycle sustained while the result channel does not stall; an input
// transfer reaches its result through the input register, then the two-entry result buffer.
// The sequencer state advances once per tick; its critical path is the 10-bit
// timer increment and compare.
// Reset (synchronous, rst_n low) sets the timing registers to defaults and the
// sequencer to idle. A stalled result channel fills the buffer, then holds in_ch.
`default_nettype none

module one_wire_bus_master (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  owbm_in_if.sink                          in_ch,
  owbm_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [owbm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  owbm_pkg::cfg_t cfg;
  owbm_pkg::res_t res;
  logic           push;
  logic           space;

  owbm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owbm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .space (space),
    .push  (push),
    .res   (res)
  );

  owbm_out_buf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
